// ===== src/swtc_pkg.sv =====
// Package: shared types, constants and the Sobel kernel function of the texture check.
`timescale 1ns / 1ps
`default_nettype none
package swtc_pkg;

  localparam int MAX_HEIGHT = 4096;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int ROW_W      = 12;
  localparam int SUM_W      = 31;
  localparam int MEAN_W     = 15;
  localparam int LEN_W      = 11;
  localparam int CNT_W      = 21;
  localparam int DIM_W      = 14;
  localparam int GRAD_W     = 12;
  localparam int SQ_W       = 29;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam int KERN_X [3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
  localparam int KERN_Y [3][3] = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_gradient;
    logic              skipped;
  } result_t;

  typedef logic [2:0][2:0][7:0] window_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_LEFT   = 3'd2,
    REG_TOP    = 3'd3,
    REG_SIDE   = 3'd4,
    REG_THRESH = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PICK,
    ST_MAG,
    ST_CNT,
    ST_DIV,
    ST_OUT
  } state_e;

  function automatic logic signed [GRAD_W-1:0] sobel_grad(input window_t win, input logic dir_y);
    int acc;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = acc + (dir_y ? KERN_Y[i][j] : KERN_X[i][j]) * int'(win[i][j]);
      end
    end
    return GRAD_W'(acc);
  endfunction

endpackage
`default_nettype wire

// ===== src/sobel_window_texture_check.sv =====
// Top level: line buffer memory, item sequencer, window sum and mean result.
//
// Pixels of one frame enter in raster order. Each pixel reads and writes back
// one entry of the line buffer RAM, then the shared magnitude unit forms up to
// four gradients. The final pixel of a frame then runs the window count, a
// 31-step divide and the result load, and also waits while the previous result
// still waits stalled at the output. After reset a clearing pass zeroes all
// MAX_WIDTH line buffer entries before the first pixel is taken. The result
// waits in an output register.
`timescale 1ns / 1ps
`default_nettype none
module sobel_window_texture_check #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 256
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire swtc_pkg::pix_in_t                   in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output swtc_pkg::result_t                        out_data_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [swtc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [swtc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int SIDE_W = $clog2(MAX_WINDOW + 1);
  localparam int DW     = swtc_pkg::DIM_W;

  swtc_pkg::state_e state_q, state_d;

  logic [10:0] cfg_width_q;
  logic [12:0] cfg_height_q;
  logic [9:0]  cfg_left_q;
  logic [11:0] cfg_top_q;
  logic [8:0]  cfg_side_q;
  logic [14:0] cfg_thresh_q;

  logic [ADDR_W-1:0] col_q, clr_q, c_q, c_in;
  logic [swtc_pkg::ROW_W-1:0] row_q, r_q, r_in;
  logic [swtc_pkg::SUM_W-1:0] sum_q;
  logic [5:0][7:0] nc_q;
  logic [7:0] pix_q;
  logic lastc_q, lastr_q, lastc_in, lastr_in, cnt_zero_q;
  swtc_pkg::window_t grid_q, grid_d, win_sel;
  logic [3:0] en_q;
  logic [1:0] k_q, k_pick;

  logic [DW-1:0] w_eff, h_eff, side_eff, lenx, leny, x_pos, y_pos;
  logic in_win;
  logic [swtc_pkg::SUM_W:0] sum_add;

  logic ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0] ram_wdata, ram_rdata;

  logic mag_start, mag_busy, mag_done;
  logic [swtc_pkg::MEAN_W-1:0] mag;
  logic div_start, div_done;
  logic [swtc_pkg::SUM_W-1:0] quot;
  logic [swtc_pkg::CNT_W-1:0] count;

  logic in_acc, out_load, out_valid_q;
  swtc_pkg::result_t out_q;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i & ~in_stall_o;

  // effective frame shape
  always_comb begin
    if (cfg_width_q == '0) begin
      w_eff = DW'(1);
    end else if (DW'(cfg_width_q) > DW'(MAX_WIDTH)) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = DW'(cfg_width_q);
    end
    if (cfg_height_q == '0) begin
      h_eff = DW'(1);
    end else if (DW'(cfg_height_q) > DW'(swtc_pkg::MAX_HEIGHT)) begin
      h_eff = DW'(swtc_pkg::MAX_HEIGHT);
    end else begin
      h_eff = DW'(cfg_height_q);
    end
    if (DW'(cfg_side_q) > DW'(MAX_WINDOW)) begin
      side_eff = DW'(SIDE_W'(MAX_WINDOW));
    end else begin
      side_eff = DW'(cfg_side_q);
    end
    if (DW'(cfg_left_q) >= w_eff) begin
      lenx = '0;
    end else if (side_eff < w_eff - DW'(cfg_left_q)) begin
      lenx = side_eff;
    end else begin
      lenx = w_eff - DW'(cfg_left_q);
    end
    if (DW'(cfg_top_q) >= h_eff) begin
      leny = '0;
    end else if (side_eff < h_eff - DW'(cfg_top_q)) begin
      leny = side_eff;
    end else begin
      leny = h_eff - DW'(cfg_top_q);
    end
  end

  assign count = swtc_pkg::CNT_W'(lenx[swtc_pkg::LEN_W-1:0] * leny[swtc_pkg::LEN_W-1:0]);

  assign c_in     = in_data_i.frame_start ? '0 : col_q;
  assign r_in     = in_data_i.frame_start ? '0 : row_q;
  assign lastc_in = (DW'(c_in) + DW'(1)) >= w_eff;
  assign lastr_in = (DW'(r_in) + DW'(1)) >= h_eff;

  // 3x3 neighborhood of the item, edges outside the image as zero
  always_comb begin
    grid_d = '0;
    for (int i = 0; i < 3; i++) begin
      if ((DW'(r_q) + DW'(i)) >= DW'(2)) begin
        if (c_q >= ADDR_W'(2)) begin
          grid_d[i][0] = nc_q[i];
        end
        if (c_q != '0) begin
          grid_d[i][1] = nc_q[3 + i];
        end
      end
    end
    if (r_q >= swtc_pkg::ROW_W'(2)) begin
      grid_d[0][2] = ram_rdata[15:8];
    end
    if (r_q != '0) begin
      grid_d[1][2] = ram_rdata[7:0];
    end
    grid_d[2][2] = pix_q;
  end

  always_comb begin
    k_pick = 2'd3;
    for (int i = 3; i >= 0; i--) begin
      if (en_q[i]) begin
        k_pick = 2'(i);
      end
    end
  end

  always_comb begin
    logic [2:0] ri, cj;
    win_sel = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ri = 3'(i) + {2'b0, k_pick[1]};
        cj = 3'(j) + {2'b0, k_pick[0]};
        if (ri < 3'd3 && cj < 3'd3) begin
          win_sel[i][j] = grid_q[ri[1:0]][cj[1:0]];
        end
      end
    end
  end

  assign x_pos   = DW'(c_q) - DW'(1) + DW'(k_q[0]);
  assign y_pos   = DW'(r_q) - DW'(1) + DW'(k_q[1]);
  assign in_win  = (x_pos >= DW'(cfg_left_q)) && ((x_pos - DW'(cfg_left_q)) < side_eff) &&
                   (y_pos >= DW'(cfg_top_q)) && ((y_pos - DW'(cfg_top_q)) < side_eff);
  assign sum_add = {1'b0, sum_q} + (swtc_pkg::SUM_W + 1)'(mag);
  assign out_load = (state_q == swtc_pkg::ST_OUT) && (!out_valid_q || !out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swtc_pkg::ST_CLEAR: if (clr_q == ADDR_W'(MAX_WIDTH - 1)) state_d = swtc_pkg::ST_IDLE;
      swtc_pkg::ST_IDLE:  if (in_acc) state_d = swtc_pkg::ST_READ;
      swtc_pkg::ST_READ:  state_d = swtc_pkg::ST_PICK;
      swtc_pkg::ST_PICK: begin
        if (en_q != '0) begin
          state_d = swtc_pkg::ST_MAG;
        end else if (lastc_q && lastr_q) begin
          state_d = swtc_pkg::ST_CNT;
        end else begin
          state_d = swtc_pkg::ST_IDLE;
        end
      end
      swtc_pkg::ST_MAG:   if (mag_done) state_d = swtc_pkg::ST_PICK;
      swtc_pkg::ST_CNT:   state_d = swtc_pkg::ST_DIV;
      swtc_pkg::ST_DIV:   if (div_done) state_d = swtc_pkg::ST_OUT;
      swtc_pkg::ST_OUT:   if (out_load) state_d = swtc_pkg::ST_IDLE;
      default:            state_d = swtc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o = 1'b1;
    ram_we     = 1'b0;
    ram_waddr  = c_q;
    ram_wdata  = {ram_rdata[7:0], pix_q};
    mag_start  = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      swtc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      swtc_pkg::ST_IDLE: in_stall_o = 1'b0;
      swtc_pkg::ST_READ: ram_we = 1'b1;
      swtc_pkg::ST_PICK: mag_start = (en_q != '0);
      swtc_pkg::ST_CNT:  div_start = 1'b1;
      default: ;
    endcase
  end

  assign ram_re = in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= swtc_pkg::ST_CLEAR;
      clr_q        <= '0;
      cfg_width_q  <= 11'd1024;
      cfg_height_q <= 13'd1024;
      cfg_left_q   <= '0;
      cfg_top_q    <= '0;
      cfg_side_q   <= 9'd32;
      cfg_thresh_q <= '0;
      col_q        <= '0;
      row_q        <= '0;
      sum_q        <= '0;
      nc_q         <= '0;
      en_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == swtc_pkg::ST_CLEAR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (swtc_pkg::reg_idx_e'(cfg_index_i))
          swtc_pkg::REG_WIDTH:  cfg_width_q  <= cfg_data_i[10:0];
          swtc_pkg::REG_HEIGHT: cfg_height_q <= cfg_data_i[12:0];
          swtc_pkg::REG_LEFT:   cfg_left_q   <= cfg_data_i[9:0];
          swtc_pkg::REG_TOP:    cfg_top_q    <= cfg_data_i[11:0];
          swtc_pkg::REG_SIDE:   cfg_side_q   <= cfg_data_i[8:0];
          swtc_pkg::REG_THRESH: cfg_thresh_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (in_acc && in_data_i.frame_start) begin
        sum_q <= '0;
      end
      if (state_q == swtc_pkg::ST_READ) begin
        nc_q <= {pix_q, ram_rdata[7:0], ram_rdata[15:8], nc_q[5:3]};
        en_q <= {lastr_q && lastc_q, lastr_q && (c_q != '0),
                 (r_q != '0) && lastc_q, (r_q != '0) && (c_q != '0)};
        if (lastc_q) begin
          col_q <= '0;
          row_q <= lastr_q ? '0 : r_q + swtc_pkg::ROW_W'(1);
        end else begin
          col_q <= c_q + ADDR_W'(1);
          row_q <= r_q;
        end
      end
      if (state_q == swtc_pkg::ST_MAG && mag_done) begin
        en_q[k_q] <= 1'b0;
        if (in_win) begin
          sum_q <= (sum_add > {1'b0, swtc_pkg::SUM_MAX}) ? swtc_pkg::SUM_MAX
                                                         : sum_add[swtc_pkg::SUM_W-1:0];
        end
      end
      if (out_load) begin
        sum_q       <= '0;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q   <= in_data_i.pixel;
      c_q     <= c_in;
      r_q     <= r_in;
      lastc_q <= lastc_in;
      lastr_q <= lastr_in;
    end
    if (state_q == swtc_pkg::ST_READ) begin
      grid_q <= grid_d;
    end
    if (mag_start) begin
      k_q <= k_pick;
    end
    if (div_start) begin
      cnt_zero_q <= (count == '0);
    end
    if (out_load) begin
      out_q.mean_gradient <= cnt_zero_q ? '0 : quot[swtc_pkg::MEAN_W-1:0];
      out_q.skipped       <= cnt_zero_q ? (cfg_thresh_q != '0)
                                        : (quot < swtc_pkg::SUM_W'(cfg_thresh_q));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  swtc_ram #(
    .WIDTH(16),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(c_in),
    .rdata_o(ram_rdata)
  );

  swtc_mag u_mag (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mag_start),
    .win_i  (win_sel),
    .busy_o (mag_busy),
    .done_o (mag_done),
    .mag_o  (mag)
  );

  swtc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_q),
    .divisor_i (count),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  a_mag_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_start |-> !mag_busy)
    else $error("magnitude unit started while busy");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == swtc_pkg::ST_DIV))
    else $error("divider finished outside its wait state");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == swtc_pkg::ST_OUT))
    else $error("result appeared without a final pixel");

endmodule
`default_nettype wire

// ===== src/swtc_ram.sv =====
// Generic RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module swtc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/swtc_mag.sv =====
// Gradient magnitude unit: Sobel sums, squares, bit-by-bit square root.
`timescale 1ns / 1ps
`default_nettype none
module swtc_mag (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire swtc_pkg::window_t          win_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [swtc_pkg::MEAN_W-1:0]     mag_o
);

  logic signed [swtc_pkg::GRAD_W-1:0] gx_q, gy_q;
  logic [swtc_pkg::SQ_W-1:0] v_q, res_q, bit_q, trial;
  logic [20:0] sq_sum;
  logic [3:0] cnt_q;
  logic sq_q, run_q, done_q;

  assign sq_sum = 21'(gx_q * gx_q) + 21'(gy_q * gy_q);
  assign trial  = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q   <= 1'b0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      sq_q   <= start_i;
      if (sq_q) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd14) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      gx_q <= swtc_pkg::sobel_grad(win_i, 1'b0);
      gy_q <= swtc_pkg::sobel_grad(win_i, 1'b1);
    end
    if (sq_q) begin
      v_q   <= {sq_sum, 8'b0};
      res_q <= '0;
      bit_q <= swtc_pkg::SQ_W'(1) << 28;
    end else if (run_q) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign busy_o = sq_q | run_q;
  assign done_o = done_q;
  assign mag_o  = res_q[swtc_pkg::MEAN_W-1:0];

endmodule
`default_nettype wire

// ===== src/swtc_div.sv =====
// Restoring divider: one quotient bit per cycle for the window mean.
`timescale 1ns / 1ps
`default_nettype none
module swtc_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [swtc_pkg::SUM_W-1:0]  dividend_i,
  input  wire logic [swtc_pkg::CNT_W-1:0]  divisor_i,
  output logic                             done_o,
  output logic [swtc_pkg::SUM_W-1:0]       quot_o
);

  logic [swtc_pkg::CNT_W-1:0] div_q, rem_q;
  logic [swtc_pkg::SUM_W-1:0] quo_q;
  logic [swtc_pkg::CNT_W:0]   shifted;
  logic [4:0] cnt_q;
  logic run_q, done_q, take;

  assign shifted = {rem_q, quo_q[swtc_pkg::SUM_W-1]};
  assign take    = shifted >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(swtc_pkg::SUM_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (run_q) begin
      rem_q <= take ? swtc_pkg::CNT_W'(shifted - {1'b0, div_q})
                    : shifted[swtc_pkg::CNT_W-1:0];
      quo_q <= {quo_q[swtc_pkg::SUM_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire
